// ===== rtl/rrss_pkg.sv =====
package rrss_pkg;

  localparam int unsigned MaxDevices = 16;
  localparam int unsigned OutLimit   = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned IndexW     = 4;
  localparam int unsigned TaskW      = 16;
  localparam int unsigned StepW      = 4;

  // effective device count ceiling
  localparam logic [CountW-1:0] CountCap =
    CountW'((MaxDevices < OutLimit) ? MaxDevices : OutLimit);

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } rrss_cmd_t;

  typedef struct packed {
    logic skip_item;
    logic div_done;
    logic out_free;
    logic emit_last;
  } rrss_stat_t;

endpackage

// ===== rtl/rrss_ctrl.sv =====
module rrss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrss_pkg::rrss_stat_t stat,
  output rrss_pkg::rrss_cmd_t  cmd
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    in_stall     = 1'b1;
    unique case (state_r)
      StIdle: begin
        in_stall = 1'b0;
        // drop transactions with zero count or zero total
        if (in_valid && !stat.skip_item) begin
          cmd.load  = 1'b1;
          state_nxt = StDiv;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = StEmit;
        end
      end
      StEmit: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_nxt = StIdle;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rrss_dp.sv =====
module rrss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rrss_pkg::CountW-1:0]   cfg_wr_data,
  input  logic [rrss_pkg::TaskW-1:0]    in_total_tasks,
  input  rrss_pkg::rrss_cmd_t           cmd,
  output rrss_pkg::rrss_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrss_pkg::IndexW-1:0]   out_device_index,
  output logic [rrss_pkg::TaskW-1:0]    out_share,
  output logic                          out_last
);

  logic [rrss_pkg::CountW-1:0] dev_count_r;
  logic [rrss_pkg::IndexW-1:0] pointer_r;
  logic [rrss_pkg::CountW-1:0] n_r;
  logic [rrss_pkg::TaskW-1:0]  quot_r;
  logic [rrss_pkg::CountW-1:0] rem_r;
  logic [rrss_pkg::CountW-1:0] start_r;
  logic [rrss_pkg::StepW-1:0]  step_r;
  logic [rrss_pkg::IndexW-1:0] dev_r;
  logic                        out_valid_r;
  logic [rrss_pkg::IndexW-1:0] out_index_r;
  logic [rrss_pkg::TaskW-1:0]  out_share_r;
  logic                        out_last_r;

  logic [rrss_pkg::CountW-1:0] eff_count;
  logic [rrss_pkg::CountW:0]   trial;
  logic                        trial_ge;
  logic [rrss_pkg::CountW-1:0] dev_ext;
  logic [rrss_pkg::CountW-1:0] offset;
  logic                        extra;
  logic [rrss_pkg::CountW:0]   ptr_sum;
  logic [rrss_pkg::CountW:0]   ptr_wrap;

  assign eff_count = (dev_count_r > rrss_pkg::CountCap) ? rrss_pkg::CountCap : dev_count_r;

  // restoring division, one quotient bit per step
  assign trial    = {rem_r, quot_r[rrss_pkg::TaskW-1]};
  assign trial_ge = (trial >= {1'b0, n_r});

  assign dev_ext = {1'b0, dev_r};
  assign offset  = (dev_ext >= start_r) ? (dev_ext - start_r) : (dev_ext + n_r - start_r);
  assign extra   = (offset < rem_r);

  assign ptr_sum  = {1'b0, start_r} + {1'b0, rem_r};
  assign ptr_wrap = (ptr_sum >= {1'b0, n_r}) ? (ptr_sum - {1'b0, n_r}) : ptr_sum;

  assign stat.skip_item = (eff_count == '0) || (in_total_tasks == '0);
  assign stat.div_done  = (step_r == {rrss_pkg::StepW{1'b1}});
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.emit_last = (dev_ext == n_r - rrss_pkg::CountW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= '0;
      pointer_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_count_r <= cfg_wr_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (stat.emit_last) begin
          pointer_r <= ptr_wrap[rrss_pkg::IndexW-1:0];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= eff_count;
      quot_r  <= in_total_tasks;
      rem_r   <= '0;
      start_r <= {1'b0, pointer_r};
      step_r  <= '0;
      dev_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_ge ? rrss_pkg::CountW'(trial - {1'b0, n_r})
                         : trial[rrss_pkg::CountW-1:0];
      quot_r <= {quot_r[rrss_pkg::TaskW-2:0], trial_ge};
      step_r <= step_r + rrss_pkg::StepW'(1);
      // reduce the pointer modulo the count alongside the division
      if (start_r >= n_r) begin
        start_r <= start_r - n_r;
      end
    end
    if (cmd.emit) begin
      out_index_r <= dev_r;
      out_share_r <= quot_r + rrss_pkg::TaskW'(extra);
      out_last_r  <= stat.emit_last;
      dev_r       <= dev_r + rrss_pkg::IndexW'(1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_device_index = out_index_r;
  assign out_share        = out_share_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/round_robin_share_splitter_unit.sv =====
// Round-robin share splitter.
// Input channel (in_valid / in_stall / in_total_tasks): one transaction is a task
// total. It is split among the configured device count: each device gets the
// quotient, and the remainder devices, counted cyclically from a rotation
// pointer, get one more. A zero total or zero count is taken and dropped.
// Result channel (out_*): one transaction per device, index 0 to count-1, with
// out_last on the final one. The pointer then advances by the remainder.
// cfg_wr_en / cfg_wr_data write the device count; write only while idle.
// Operation: after acceptance, bit-serial division (one quotient bit per cycle,
// which also reduces the pointer), then one result per cycle while the
// receiver does not stall.
// in_stall is high from acceptance until the last result is registered.
// A stalled result holds in the output register and pauses emission.
// Reset clears the device count, the pointer and the output valid.
module round_robin_share_splitter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rrss_pkg::CountW-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rrss_pkg::TaskW-1:0]  in_total_tasks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrss_pkg::IndexW-1:0] out_device_index,
  output logic [rrss_pkg::TaskW-1:0]  out_share,
  output logic                        out_last
);

  rrss_pkg::rrss_cmd_t  cmd;
  rrss_pkg::rrss_stat_t stat;

  rrss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_total_tasks   (in_total_tasks),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_device_index (out_device_index),
    .out_share        (out_share),
    .out_last         (out_last)
  );

  // a run continues without gaps once the receiver takes a result
  a_run_advances: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_device_index == $past(out_device_index) + 4'd1))
    else $error("result run did not advance to the next device");

  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted while a run is in progress");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !$past(out_valid) && cmd.emit == 1'b0 |-> out_device_index == 4'd0
      || $past(out_valid))
    else $error("run did not start at device zero");

  a_div_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.div_step && !cmd.emit)
    else $error("emission started before the division");

endmodule
